// File: hdl/mso_pkg.sv
`timescale 1ns / 1ps
// Package for the largest all-ones square block: sizes, types and the
// small arithmetic helpers. Depends on nothing.
package mso_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_RUN  = 1024;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int SIDE_W = 11;
    localparam int AREA_W = 21;

    typedef logic [COL_W-1:0]  col_t;
    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [AREA_W-1:0] area_t;

    localparam side_t ROW_WIDTH_RESET = side_t'(MAX_COLS);
    localparam side_t RUN_LIMIT       = side_t'(MAX_RUN);

    // One line buffer entry: run of ones upward and square side of the row above
    typedef struct packed {
        side_t vert_run;
        side_t sq_side;
    } line_entry_t;

    // Increment a run, holding it at the bound
    function automatic side_t sat_inc(input side_t v);
        side_t r;
        r = (v >= RUN_LIMIT) ? RUN_LIMIT : side_t'(v + side_t'(1));
        return r;
    endfunction

    function automatic side_t min_side(input side_t a, input side_t b);
        side_t r;
        r = (a < b) ? a : b;
        return r;
    endfunction

endpackage

// File: hdl/mso_cell_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one matrix cell per beat.
// Depends on nothing.
interface mso_cell_if;
    logic valid;
    logic ready;
    logic cell_req;
    logic last_cell;

    modport source (output valid, output cell_req, output last_cell, input ready);
    modport sink   (input valid, input cell_req, input last_cell, output ready);
endinterface

// File: hdl/mso_result_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying the largest square side and its area per beat.
// Depends on mso_pkg for the field widths.
interface mso_result_if;
    import mso_pkg::*;
    logic  valid;
    logic  ready;
    side_t best_side;
    area_t best_area;

    modport source (output valid, output best_side, output best_area, input ready);
    modport sink   (input valid, input best_side, input best_area, output ready);
endinterface

// File: hdl/maximal_square_of_ones.sv
`timescale 1ns / 1ps
// Top level of the largest all-ones square finder over a raster cell stream.
// Depends on mso_pkg, mso_cell_if and mso_result_if.
//
// Usage:
//   cells   : one matrix cell per beat in raster order; last_cell marks the
//             final cell of a matrix.
//   results : one beat per matrix, the largest square side and its area.
//   cfg_wr_en / cfg_wr_data : write the row width while the block is idle.
// Throughput: one cell per cycle. Each cell reads its column of the line
// buffer at acceptance and writes it back the next cycle; a same-column
// write that coincides with the read is forwarded, so a row width of one
// also runs at full rate.
// A last cell's result passes the compute and area stages before the queue.
// Results queue in a two-entry output buffer; cells keep flowing while a
// result waits, and input stalls only when two results are pending.
// Reset: row width returns to 1024, the column counter to the top left
// corner and the queue empties. The line buffer needs no clearing pass.
module maximal_square_of_ones
    import mso_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mso_cell_if.sink             cells,
    mso_result_if.source         results,
    input  logic                 cfg_wr_en,
    input  logic [SIDE_W-1:0]    cfg_wr_data
);

    // Configuration and acceptance-side position
    side_t row_width_reg;
    col_t  col_reg,   col_next;
    logic  first_row_reg, first_row_next;
    side_t width_eff;
    logic  accept;

    // Line buffer
    line_entry_t line_mem [MAX_COLS];
    line_entry_t rd_data_reg;

    // Compute stage
    logic        s1_valid_reg;
    logic        s1_cell_reg;
    logic        s1_last_reg;
    logic        s1_first_reg;
    col_t        s1_col_reg;
    logic        fwd_hit_reg;
    line_entry_t fwd_data_reg;
    line_entry_t above;
    line_entry_t wr_data;
    side_t       up_run, left_run, side, best_now;
    side_t       h_run_reg,   h_run_next;
    side_t       diag_reg,    diag_next;
    side_t       largest_reg, largest_next;

    // Area stage
    logic  s2_valid_reg;
    side_t s2_side_reg;
    area_t s2_area;

    // Result queue
    side_t      q_side_reg [2];
    area_t      q_area_reg [2];
    logic       q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0] q_count_reg;
    logic [2:0] pending;
    logic       push, pop;

    // Hold a new cell back only when both result slots could be taken
    assign pending = 3'(q_count_reg) + 3'(s1_valid_reg & s1_last_reg)
                   + 3'(s2_valid_reg);
    assign cells.ready = (pending <= 3'd1);
    assign accept      = cells.valid & cells.ready;

    // Clamp the row width into its legal range
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            width_eff = side_t'(1);
        end
        else if (row_width_reg > side_t'(MAX_COLS))
        begin
            width_eff = side_t'(MAX_COLS);
        end
        else
        begin
            width_eff = row_width_reg;
        end
    end

    // Advance the column counter, wrap at row end, restart on the last cell
    always_comb
    begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if ((side_t'(col_reg) + side_t'(1)) >= width_eff)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_t'(col_reg + col_t'(1));
            end
            if (cells.last_cell)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                row_width_reg <= cfg_wr_data;
            end
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    // Line buffer: read at the acceptance column, write back from compute stage
    always_ff @(posedge clk)
    begin
        rd_data_reg <= line_mem[col_reg];
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    // Capture the beat and any write-back that the read just missed
    always_ff @(posedge clk)
    begin
        s1_cell_reg  <= cells.cell_req;
        s1_last_reg  <= cells.last_cell;
        s1_first_reg <= first_row_reg;
        s1_col_reg   <= col_reg;
        fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == col_reg);
        fwd_data_reg <= wr_data;
    end

    // Work out the runs and the square side for the cell in flight
    always_comb
    begin
        above = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

        if (s1_first_reg)
        begin
            up_run = side_t'(s1_cell_reg);
        end
        else
        begin
            up_run = s1_cell_reg ? sat_inc(above.vert_run) : '0;
        end

        if (s1_col_reg == '0)
        begin
            left_run = side_t'(s1_cell_reg);
        end
        else
        begin
            left_run = s1_cell_reg ? sat_inc(h_run_reg) : '0;
        end

        if (s1_first_reg || (s1_col_reg == '0))
        begin
            side = side_t'(s1_cell_reg);
        end
        else
        begin
            side = min_side(side_t'(diag_reg + side_t'(1)), min_side(up_run, left_run));
        end

        wr_data.vert_run = up_run;
        wr_data.sq_side  = side;
        best_now         = (side > largest_reg) ? side : largest_reg;

        h_run_next   = h_run_reg;
        diag_next    = diag_reg;
        largest_next = largest_reg;
        if (s1_valid_reg)
        begin
            h_run_next   = left_run;
            diag_next    = above.sq_side;
            largest_next = best_now;
            if (s1_last_reg)
            begin
                h_run_next   = '0;
                diag_next    = '0;
                largest_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            h_run_reg    <= '0;
            diag_reg     <= '0;
            largest_reg  <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            h_run_reg    <= h_run_next;
            diag_reg     <= diag_next;
            largest_reg  <= largest_next;
            s2_valid_reg <= s1_valid_reg & s1_last_reg;
        end
    end

    // Register the final side, square it in the next cycle
    always_ff @(posedge clk)
    begin
        s2_side_reg <= best_now;
    end

    assign s2_area = area_t'(s2_side_reg) * area_t'(s2_side_reg);

    // Two-entry result queue
    assign push = s2_valid_reg;
    assign pop  = results.valid & results.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_side_reg[q_wr_ptr_reg] <= s2_side_reg;
            q_area_reg[q_wr_ptr_reg] <= s2_area;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (pop)
            begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
            q_count_reg <= 2'(q_count_reg + 2'(push) - 2'(pop));
        end
    end

    assign results.valid     = (q_count_reg != '0);
    assign results.best_side = q_side_reg[q_rd_ptr_reg];
    assign results.best_area = q_area_reg[q_rd_ptr_reg];

    // Checks
    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= 2'd2)
        else $error("result queue overfilled");

    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (q_count_reg != 2'd2) || pop)
        else $error("result pushed into a full queue");

    a_restart : assert property (@(posedge clk) disable iff (!rst_n)
        accept && cells.last_cell |=> (col_reg == '0) && first_row_reg)
        else $error("position not cleared after last cell");

    a_last_result : assert property (@(posedge clk) disable iff (!rst_n)
        accept && cells.last_cell |=> ##1 s2_valid_reg)
        else $error("last cell gave no result");

endmodule
